// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; each macro wraps one clocked concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lrgs_pkg.sv =====
// shared constants, codes and types of the gradient step core
// no dependencies; imported by the interfaces and every module
`timescale 1ns / 1ps
`default_nettype none

package lrgs_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int SUM_W       = 64;
   localparam int COST_W      = 63;
   localparam int USED_W      = 11;
   localparam int RES_W       = 48;
   localparam int RMAG_W      = RES_W - 1;
   localparam int STEP_W      = 34;

   // divider: 64-bit dividend, divisor up to twice the sample count
   localparam int DIVD_W    = 64;
   localparam int DIVR_W    = CNT_W + 1;
   localparam int DIV_CNT_W = $clog2(DIVD_W);

   localparam logic [DATA_W-1:0]        LR_RESET = 32'd2147484;
   localparam logic signed [DATA_W-1:0] ONE_Q16  = 32'sd65536;
   localparam logic [COST_W-1:0]        COST_MAX = {COST_W{1'b1}};
   localparam logic [STEP_W-1:0]        STEP_MAX = 34'h2_0000_0000;

   typedef logic [1:0] action_type;
   localparam action_type ACT_LOAD   = 2'd0;
   localparam action_type ACT_EVAL   = 2'd1;
   localparam action_type ACT_UPDATE = 2'd2;
   localparam action_type ACT_NONE   = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/lrgs_if.sv =====
// valid/ready channel interfaces: request, response and csr write
// depends on lrgs_pkg for field widths and the action type
`timescale 1ns / 1ps
`default_nettype none

interface lrgs_req_if import lrgs_pkg::*; ();
   logic              valid;
   logic              ready;
   action_type        action;
   logic [DATA_W-1:0] sample_x;
   logic [DATA_W-1:0] sample_y;

   modport source (output valid, output action, output sample_x, output sample_y,
                   input ready);
   modport sink   (input valid, input action, input sample_x, input sample_y,
                   output ready);
endinterface

interface lrgs_rsp_if import lrgs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] mean_cost;
   logic [DATA_W-1:0] intercept_out;
   logic [DATA_W-1:0] slope_out;
   logic [USED_W-1:0] used_samples;

   modport source (output valid, output mean_cost, output intercept_out,
                   output slope_out, output used_samples, input ready);
   modport sink   (input valid, input mean_cost, input intercept_out,
                   input slope_out, input used_samples, output ready);
endinterface

interface lrgs_csr_if import lrgs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] step_size;

   modport source (output valid, output step_size, input ready);
   modport sink   (input valid, input step_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/linear_regression_gradient_step_core.sv =====
// top level: sample stores, sequencer and accumulators of the gradient step core
// depends on lrgs_pkg, lrgs_if, lrgs_mul and lrgs_div
//
//   channel  dir  transaction         payload
//   req      in   one item            action, sample_x, sample_y
//   rsp      out  one result          mean_cost, intercept_out, slope_out, used_samples
//   csr      in   step size write     step_size
//
// evaluate walks each of the N stored samples through the shared multiplier,
// then runs the 64-step divider for the cost unless the square sum saturated;
// with no samples it does neither. update first runs two divides if N > 0.
// reset is synchronous; the sample stores are not cleared and hold nothing
// until loaded. req is not ready during an evaluation; a finished result waits
// in the output register, and a second result waits until that one is taken.
`timescale 1ns / 1ps
`default_nettype none

module linear_regression_gradient_step_core import lrgs_pkg::*; (
   input logic         clock,
   input logic         reset,
   lrgs_req_if.sink    req_port,
   lrgs_rsp_if.source  rsp_port,
   lrgs_csr_if.sink    csr_port
);

   localparam int STATE_W = 5;
   localparam logic [STATE_W-1:0] ST_IDLE      = 5'd0;
   localparam logic [STATE_W-1:0] ST_UPD_MAG   = 5'd1;
   localparam logic [STATE_W-1:0] ST_UPD_LO    = 5'd2;
   localparam logic [STATE_W-1:0] ST_UPD_HI    = 5'd3;
   localparam logic [STATE_W-1:0] ST_UPD_SUM   = 5'd4;
   localparam logic [STATE_W-1:0] ST_UPD_DIV   = 5'd5;
   localparam logic [STATE_W-1:0] ST_UPD_WAIT  = 5'd6;
   localparam logic [STATE_W-1:0] ST_EVAL_INIT = 5'd7;
   localparam logic [STATE_W-1:0] ST_READ      = 5'd8;
   localparam logic [STATE_W-1:0] ST_MAG       = 5'd9;
   localparam logic [STATE_W-1:0] ST_MUL_XS    = 5'd10;
   localparam logic [STATE_W-1:0] ST_RES       = 5'd11;
   localparam logic [STATE_W-1:0] ST_RMAG      = 5'd12;
   localparam logic [STATE_W-1:0] ST_MUL_RLO   = 5'd13;
   localparam logic [STATE_W-1:0] ST_MUL_RHI   = 5'd14;
   localparam logic [STATE_W-1:0] ST_MUL_RR    = 5'd15;
   localparam logic [STATE_W-1:0] ST_ACC       = 5'd16;
   localparam logic [STATE_W-1:0] ST_COST      = 5'd17;
   localparam logic [STATE_W-1:0] ST_COST_WAIT = 5'd18;
   localparam logic [STATE_W-1:0] ST_DONE      = 5'd19;

   function automatic logic [SUM_W-1:0] sat64(input logic [SUM_W:0] s);
      if (s[SUM_W] != s[SUM_W-1]) begin
         sat64 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sat64 = s[SUM_W-1:0];
      end
   endfunction

   // control and parameter state
   logic [STATE_W-1:0] state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DATA_W-1:0]  lr_ff, lr_in;
   logic [DATA_W-1:0]  intercept_ff, intercept_in;
   logic [DATA_W-1:0]  slope_ff, slope_in;
   logic [SUM_W-1:0]   rsum_ff, rsum_in;
   logic [SUM_W-1:0]   rxsum_ff, rxsum_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               upd_sel_ff, upd_sel_in;
   logic [SUM_W-1:0]   umag_ff, umag_in;
   logic               uneg_ff, uneg_in;
   logic [SUM_W-1:0]   ustep_ff, ustep_in;
   logic [DATA_W-1:0]  smag_ff, smag_in;
   logic               sneg_ff, sneg_in;
   logic [DATA_W-1:0]  xmag_ff, xmag_in;
   logic               xneg_ff, xneg_in;
   logic [DATA_W-1:0]  y_ff, y_in;
   logic [RES_W-1:0]   r_ff, r_in;
   logic [RMAG_W-1:0]  rmag_ff, rmag_in;
   logic               rneg_ff, rneg_in;
   logic [SUM_W-1:0]   rx_ff, rx_in;
   logic [COST_W-1:0]  sq_ff, sq_in;
   logic               sat_ff, sat_in;
   logic [COST_W-1:0]  cost_ff, cost_in;

   logic [COST_W-1:0]  out_cost_ff;
   logic [DATA_W-1:0]  out_int_ff;
   logic [DATA_W-1:0]  out_slope_ff;
   logic [USED_W-1:0]  out_used_ff;
   logic               out_load;

   // sample stores
   logic [DATA_W-1:0]  x_mem [MAX_SAMPLES];
   logic [DATA_W-1:0]  y_mem [MAX_SAMPLES];
   logic [DATA_W-1:0]  x_rd_ff, y_rd_ff;
   logic               mem_wr, mem_rd;

   mul_req_type        mul_req;
   logic [PROD_W-1:0]  product;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               req_acc;
   logic [CNT_W-1:0]   idx_next;
   logic [SUM_W-1:0]   usum;
   logic [RES_W-1:0]   xs_mag, xs, r_abs;
   logic [SUM_W:0]     acc_ext;
   logic [SUM_W:0]     sq_sum;
   logic [STEP_W-1:0]  step;
   logic [STEP_W:0]    p_ext, v_ext;
   logic [DATA_W-1:0]  p_sel, p_new;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign idx_next       = idx_ff + 1'b1;

   lrgs_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   lrgs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lr_in        = lr_ff;
      intercept_in = intercept_ff;
      slope_in     = slope_ff;
      rsum_in      = rsum_ff;
      rxsum_in     = rxsum_ff;
      idx_in       = idx_ff;
      upd_sel_in   = upd_sel_ff;
      umag_in      = umag_ff;
      uneg_in      = uneg_ff;
      ustep_in     = ustep_ff;
      smag_in      = smag_ff;
      sneg_in      = sneg_ff;
      xmag_in      = xmag_ff;
      xneg_in      = xneg_ff;
      y_in         = y_ff;
      r_in         = r_ff;
      rmag_in      = rmag_ff;
      rneg_in      = rneg_ff;
      rx_in        = rx_ff;
      sq_in        = sq_ff;
      sat_in       = sat_ff;
      cost_in      = cost_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      out_load     = 1'b0;
      mul_req.a    = '0;
      mul_req.b    = '0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      usum    = upd_sel_ff ? rxsum_ff : rsum_ff;
      xs_mag  = {1'b0, product[RMAG_W+15:16]};
      xs      = (xneg_ff ^ sneg_ff) ? (RES_W'(0) - xs_mag) : xs_mag;
      r_abs   = r_ff[RES_W-1] ? (RES_W'(0) - r_ff) : r_ff;
      acc_ext = '0;
      sq_sum  = {2'b0, sq_ff} + {1'b0, product};
      step    = (div_rsp.quotient > {{(DIVD_W-STEP_W){1'b0}}, STEP_MAX}) ? STEP_MAX
                : div_rsp.quotient[STEP_W-1:0];
      p_sel   = upd_sel_ff ? slope_ff : intercept_ff;
      p_ext   = {{(STEP_W+1-DATA_W){p_sel[DATA_W-1]}}, p_sel};
      v_ext   = uneg_ff ? (p_ext + {1'b0, step}) : (p_ext - {1'b0, step});
      if (!v_ext[STEP_W] && (v_ext[STEP_W-1:DATA_W-1] != '0)) begin
         p_new = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v_ext[STEP_W] && (v_ext[STEP_W-1:DATA_W-1] != '1)) begin
         p_new = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         p_new = v_ext[DATA_W-1:0];
      end

      if (csr_port.valid) begin
         lr_in = csr_port.step_size;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_port.action)
                  ACT_LOAD: begin
                     // loads past capacity are dropped
                     if (count_ff < CNT_W'(MAX_SAMPLES)) begin
                        mem_wr   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_EVAL: begin
                     state_in = ST_EVAL_INIT;
                  end
                  ACT_UPDATE: begin
                     upd_sel_in = 1'b0;
                     state_in   = (count_ff != '0) ? ST_UPD_MAG : ST_EVAL_INIT;
                  end
                  ACT_NONE: begin
                  end
               endcase
            end
         end
         ST_UPD_MAG: begin
            umag_in  = usum[SUM_W-1] ? (SUM_W'(0) - usum) : usum;
            uneg_in  = usum[SUM_W-1];
            state_in = ST_UPD_LO;
         end
         ST_UPD_LO: begin
            mul_req.a = umag_ff[DATA_W-1:0];
            mul_req.b = lr_ff;
            state_in  = ST_UPD_HI;
         end
         ST_UPD_HI: begin
            mul_req.a = umag_ff[SUM_W-1:DATA_W];
            mul_req.b = lr_ff;
            ustep_in  = {{DATA_W{1'b0}}, product[PROD_W-1:DATA_W]};
            state_in  = ST_UPD_SUM;
         end
         ST_UPD_SUM: begin
            // (|sum| * rate) >> 32 = (lo*rate >> 32) + hi*rate
            ustep_in = ustep_ff + product;
            state_in = ST_UPD_DIV;
         end
         ST_UPD_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = ustep_ff;
            div_req.divisor  = {1'b0, count_ff};
            state_in         = ST_UPD_WAIT;
         end
         ST_UPD_WAIT: begin
            if (div_rsp.done) begin
               if (upd_sel_ff) begin
                  slope_in = p_new;
                  state_in = ST_EVAL_INIT;
               end else begin
                  intercept_in = p_new;
                  upd_sel_in   = 1'b1;
                  state_in     = ST_UPD_MAG;
               end
            end
         end
         ST_EVAL_INIT: begin
            rsum_in  = '0;
            rxsum_in = '0;
            sq_in    = '0;
            sat_in   = 1'b0;
            idx_in   = '0;
            smag_in  = slope_ff[DATA_W-1] ? (DATA_W'(0) - slope_ff) : slope_ff;
            sneg_in  = slope_ff[DATA_W-1];
            if (count_ff == '0) begin
               cost_in  = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_rd   = 1'b1;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            xmag_in  = x_rd_ff[DATA_W-1] ? (DATA_W'(0) - x_rd_ff) : x_rd_ff;
            xneg_in  = x_rd_ff[DATA_W-1];
            y_in     = y_rd_ff;
            state_in = ST_MUL_XS;
         end
         ST_MUL_XS: begin
            mul_req.a = xmag_ff;
            mul_req.b = smag_ff;
            state_in  = ST_RES;
         end
         ST_RES: begin
            // residual = intercept + (x*slope >> 16) - y, exact in 48 bits
            r_in = {{(RES_W-DATA_W){intercept_ff[DATA_W-1]}}, intercept_ff} + xs
                   - {{(RES_W-DATA_W){y_ff[DATA_W-1]}}, y_ff};
            state_in = ST_RMAG;
         end
         ST_RMAG: begin
            rmag_in  = r_abs[RMAG_W-1:0];
            rneg_in  = r_ff[RES_W-1];
            rsum_in  = sat64({rsum_ff[SUM_W-1], rsum_ff}
                             + {{(SUM_W+1-RES_W){r_ff[RES_W-1]}}, r_ff});
            state_in = ST_MUL_RLO;
         end
         ST_MUL_RLO: begin
            mul_req.a = rmag_ff[DATA_W-1:0];
            mul_req.b = xmag_ff;
            state_in  = ST_MUL_RHI;
         end
         ST_MUL_RHI: begin
            mul_req.a = {{(2*DATA_W-RMAG_W){1'b0}}, rmag_ff[RMAG_W-1:DATA_W]};
            mul_req.b = xmag_ff;
            rx_in     = {16'b0, product[PROD_W-1:16]};
            state_in  = ST_MUL_RR;
         end
         ST_MUL_RR: begin
            mul_req.a = rmag_ff[DATA_W-1:0];
            mul_req.b = rmag_ff[DATA_W-1:0];
            rx_in     = rx_ff + {product[SUM_W-17:0], 16'b0};
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            if (rneg_ff ^ xneg_ff) begin
               acc_ext = {rxsum_ff[SUM_W-1], rxsum_ff} - {1'b0, rx_ff};
            end else begin
               acc_ext = {rxsum_ff[SUM_W-1], rxsum_ff} + {1'b0, rx_ff};
            end
            rxsum_in = sat64(acc_ext);
            // square saturates once |r| reaches 2^32 or the sum passes 2^63-1
            if (!sat_ff) begin
               if ((rmag_ff[RMAG_W-1:DATA_W] != '0) || (sq_sum[SUM_W:COST_W] != '0)) begin
                  sat_in = 1'b1;
                  sq_in  = COST_MAX;
               end else begin
                  sq_in = sq_sum[COST_W-1:0];
               end
            end
            idx_in   = idx_next;
            state_in = (idx_next == count_ff) ? ST_COST : ST_READ;
         end
         ST_COST: begin
            if (sat_ff) begin
               cost_in  = COST_MAX;
               state_in = ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {1'b0, sq_ff};
               div_req.divisor  = {count_ff, 1'b0};
               state_in         = ST_COST_WAIT;
            end
         end
         ST_COST_WAIT: begin
            if (div_rsp.done) begin
               cost_in  = div_rsp.quotient[COST_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         lr_ff        <= LR_RESET;
         intercept_ff <= ONE_Q16;
         slope_ff     <= ONE_Q16;
         rsum_ff      <= '0;
         rxsum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lr_ff        <= lr_in;
         intercept_ff <= intercept_in;
         slope_ff     <= slope_in;
         rsum_ff      <= rsum_in;
         rxsum_ff     <= rxsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      upd_sel_ff <= upd_sel_in;
      umag_ff    <= umag_in;
      uneg_ff    <= uneg_in;
      ustep_ff   <= ustep_in;
      smag_ff    <= smag_in;
      sneg_ff    <= sneg_in;
      xmag_ff    <= xmag_in;
      xneg_ff    <= xneg_in;
      y_ff       <= y_in;
      r_ff       <= r_in;
      rmag_ff    <= rmag_in;
      rneg_ff    <= rneg_in;
      rx_ff      <= rx_in;
      sq_ff      <= sq_in;
      sat_ff     <= sat_in;
      cost_ff    <= cost_in;
      if (out_load) begin
         out_cost_ff  <= cost_ff;
         out_int_ff   <= intercept_ff;
         out_slope_ff <= slope_ff;
         out_used_ff  <= USED_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         x_mem[count_ff[ADDR_W-1:0]] <= req_port.sample_x;
         y_mem[count_ff[ADDR_W-1:0]] <= req_port.sample_y;
      end
      if (mem_rd) begin
         x_rd_ff <= x_mem[idx_ff[ADDR_W-1:0]];
         y_rd_ff <= y_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.mean_cost     = out_cost_ff;
   assign rsp_port.intercept_out = out_int_ff;
   assign rsp_port.slope_out     = out_slope_ff;
   assign rsp_port.used_samples  = out_used_ff;

endmodule

`default_nettype wire

// ===== rtl/lrgs_mul.sv =====
// shared 32x32 unsigned multiplier with a registered 64-bit product
// depends on lrgs_pkg; operands are selected by the sequencer
`timescale 1ns / 1ps
`default_nettype none

module lrgs_mul import lrgs_pkg::*; (
   input  logic              clock,
   input  mul_req_type       mul_req,
   output logic [PROD_W-1:0] product
);

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = mul_req.a * mul_req.b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ===== rtl/lrgs_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on lrgs_pkg for widths and the request/response structs
`timescale 1ns / 1ps
`default_nettype none

module lrgs_div import lrgs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIVR_W-1:0]    divisor_ff, divisor_in;
   logic [DIVD_W-1:0]    quot_ff, quot_in;
   logic [DIVR_W:0]      trial;
   logic [DIVR_W:0]      diff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      trial      = {rem_ff, quot_ff[DIVD_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(DIVD_W - 1);
         rem_in     = '0;
         divisor_in = div_req.divisor;
         quot_in    = div_req.dividend;
      end else if (busy_ff) begin
         // dividend bits shift out the top while quotient bits enter below
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in  = diff[DIVR_W-1:0];
            quot_in = {quot_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIVR_W-1:0];
            quot_in = {quot_ff[DIVD_W-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/lrgs_checker.sv =====
// port-level checks of the gradient step core, bound to the top level
// depends on lrgs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lrgs_checker import lrgs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input action_type        req_action,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [USED_W-1:0] rsp_used_samples
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped while stalled")

   `ASSERT_NEXT(a_busy_after_eval, clock, reset, req_valid && req_ready && (req_action == ACT_EVAL || req_action == ACT_UPDATE), !req_ready, "req still ready after an evaluate transaction")

   `ASSERT_NEXT(a_ready_after_load, clock, reset, req_valid && req_ready && req_action == ACT_LOAD, req_ready, "req not ready after a load transaction")

   `ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready), "result appeared while the core was idle")

   `ASSERT_IMPL(a_used_bound, clock, reset, rsp_valid, rsp_used_samples <= USED_W'(MAX_SAMPLES), "used_samples beyond store depth")

endmodule

bind linear_regression_gradient_step_core lrgs_checker u_lrgs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .req_action       (req_port.action),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_used_samples (rsp_port.used_samples)
);

`default_nettype wire

// ===== test/tb.sv =====
// self-checking bench for the linear regression gradient step core
// depends on lrgs_pkg, the lrgs_if channel interfaces and the core's rtl
// a built-in fit predictor checks every result across several step sizes
`timescale 1ns / 1ps

module tb;
   import lrgs_pkg::*;

   localparam int          SETTLE_CYCLES  = 16;
   localparam int          TAIL_CYCLES    = 100;
   localparam int          HOLD_CYCLES    = 3000;
   localparam int          WATCHDOG_LIMIT = 40000;
   localparam logic [63:0] SQ_MAX         = {1'b0, COST_MAX};
   localparam longint      SUM_HI         = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint      SUM_LO         = -SUM_HI - 1;
   localparam longint      PARAM_HI       = 64'sd2147483647;
   localparam longint      PARAM_LO       = -64'sd2147483648;
   localparam logic [63:0] STEP_CAP       = 64'h2_0000_0000;

   typedef struct packed {
      action_type        act;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
   } fit_request_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [DATA_W-1:0] icpt;
      logic [DATA_W-1:0] slope;
      logic [USED_W-1:0] used;
   } fit_result_type;

   logic clock;
   logic reset;

   lrgs_req_if req_ch ();
   lrgs_rsp_if rsp_ch ();
   lrgs_csr_if csr_ch ();

   linear_regression_gradient_step_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   // fit predictor state
   int          x_mem [MAX_SAMPLES];
   int          y_mem [MAX_SAMPLES];
   int unsigned stored = 0;
   int          icpt   = ONE_Q16;
   int          slp    = ONE_Q16;
   longint      rsum   = 0;
   longint      rxsum  = 0;
   logic [31:0] rate   = LR_RESET;

   fit_request_type queued_requests [$];
   fit_result_type  expected_fits [$];
   fit_request_type next_req;
   fit_result_type  got_fit;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_go        = 1'b0;
   bit          hold_done;
   int unsigned hold_left;
   int unsigned quiet_cycles   = 0;
   int unsigned mismatches     = 0;

   function automatic logic [63:0] abs64(longint v);
      logic [63:0] m;
      m = v;
      if (v < 0) m = -m;
      return m;
   endfunction

   // (a*b) >> 16 on magnitudes, so it truncates toward zero, then saturates
   function automatic longint mul_shift_q16(longint a, longint b);
      logic [127:0] p;
      p = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) >> 16;
      if ((a < 0) != (b < 0)) begin
         if (p > 128'h8000_0000_0000_0000) p = 128'h8000_0000_0000_0000;
         return -longint'(p[63:0]);
      end
      if (p > {64'd0, SQ_MAX}) p = {64'd0, SQ_MAX};
      return longint'(p[63:0]);
   endfunction

   function automatic longint add_sat64(longint a, longint b);
      logic signed [64:0] s;
      s = a;
      s = s + b;
      if (s[64] != s[63]) return s[64] ? SUM_LO : SUM_HI;
      return longint'(s[63:0]);
   endfunction

   function automatic int step_param(int p, longint sum, int unsigned n);
      logic [127:0] prod;
      logic [63:0]  step;
      longint       v;
      prod = ({64'd0, abs64(sum)} * {96'd0, rate}) >> 32;
      step = (prod > {64'd0, SQ_MAX}) ? SQ_MAX : prod[63:0];
      step = step / n;
      if (step > STEP_CAP) step = STEP_CAP;
      v = (sum < 0) ? longint'(p) + longint'(step) : longint'(p) - longint'(step);
      if (v > PARAM_HI) v = PARAM_HI;
      if (v < PARAM_LO) v = PARAM_LO;
      return int'(v);
   endfunction

   // walks the stored samples, saves both gradient sums, returns the cost
   function automatic logic [63:0] evaluate_fit();
      longint       s0, s1, r;
      logic [63:0]  sq, mg;
      logic [127:0] p;
      bit           sat;
      int unsigned  i;
      s0  = 0;
      s1  = 0;
      sq  = 0;
      sat = 1'b0;
      for (i = 0; i < stored; i++) begin
         r = longint'(icpt) + mul_shift_q16(longint'(x_mem[i]), longint'(slp))
             - longint'(y_mem[i]);
         s0 = add_sat64(s0, r);
         s1 = add_sat64(s1, mul_shift_q16(r, longint'(x_mem[i])));
         mg = abs64(r);
         p  = {64'd0, mg} * {64'd0, mg};
         if (p[127:64] != 0 || p[63:0] > SQ_MAX || p[63:0] > SQ_MAX - sq) begin
            sat = 1'b1;
            sq  = SQ_MAX;
         end else begin
            sq = sq + p[63:0];
         end
      end
      rsum  = s0;
      rxsum = s1;
      if (stored == 0) return 64'd0;
      if (sat) return SQ_MAX;
      return sq / (64'd2 * stored);
   endfunction

   function automatic void apply_request(fit_request_type rq);
      fit_result_type res;
      logic [63:0] cost;
      case (rq.act)
         ACT_LOAD: begin
            // loads past capacity are dropped
            if (stored < MAX_SAMPLES) begin
               x_mem[stored] = rq.x;
               y_mem[stored] = rq.y;
               stored = stored + 1;
            end
         end
         ACT_EVAL, ACT_UPDATE: begin
            if (rq.act == ACT_UPDATE && stored != 0) begin
               icpt = step_param(icpt, rsum, stored);
               slp  = step_param(slp, rxsum, stored);
            end
            cost      = evaluate_fit();
            res.cost  = cost[COST_W-1:0];
            res.icpt  = icpt;
            res.slope = slp;
            res.used  = USED_W'(stored);
            expected_fits.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic void push_request(action_type act, logic [31:0] x, logic [31:0] y);
      fit_request_type rq;
      rq.act = act;
      rq.x   = x;
      rq.y   = y;
      queued_requests.push_back(rq);
   endfunction

   // samples near y = 2x + 1 with some noise, now and then a far outlier
   function automatic void push_sample();
      int sx, sy;
      sx = $urandom_range(1 << 20);
      sx -= 1 << 19;
      if ($urandom_range(7) == 0) begin
         sy = $urandom_range(1 << 24);
         sy -= 1 << 23;
      end else begin
         sy = $urandom_range(1 << 16);
         sy += 2 * sx + ONE_Q16 - (1 << 15);
      end
      push_request(ACT_LOAD, sx, sy);
   endfunction

   // epochs: a few loads, then a run of updates and evaluations, now and then a no-op
   function automatic void queue_epochs(int count);
      int left, k;
      left = count;
      while (left > 0) begin
         k = $urandom_range(4);
         repeat (k) begin
            if (left > 0) begin
               push_sample();
               left--;
            end
         end
         k = $urandom_range(1, 5);
         repeat (k) begin
            if (left > 0) begin
               push_request(($urandom_range(3) == 0) ? ACT_EVAL : ACT_UPDATE,
                            $urandom(), $urandom());
               left--;
            end
         end
         if ($urandom_range(9) == 0)
            push_request(ACT_NONE, $urandom(), $urandom());
      end
   endfunction

   task automatic settle();
      do @(posedge clock);
      while (queued_requests.size() != 0 || req_ch.valid || expected_fits.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(logic [31:0] v);
      csr_ch.valid     <= 1'b1;
      csr_ch.step_size <= v;
      do @(posedge clock);
      while (!csr_ch.ready);
      rate = v;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_phase(logic [31:0] r, int unsigned idle, int unsigned stall, int count);
      settle();
      write_rate(r);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      queue_epochs(count);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_LOAD;
      req_ch.sample_x  = '0;
      req_ch.sample_y  = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.step_size = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            next_req.act = req_ch.action;
            next_req.x   = req_ch.sample_x;
            next_req.y   = req_ch.sample_y;
            apply_request(next_req);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = queued_requests.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.action   <= next_req.act;
               req_ch.sample_x <= next_req.x;
               req_ch.sample_y <= next_req.y;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result sink: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_done    <= 1'b0;
         hold_left    <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_fits.size() == 0) begin
            $error("result with no evaluation outstanding: mean_cost %0d", rsp_ch.mean_cost);
            mismatches++;
         end else begin
            got_fit = expected_fits.pop_front();
            if (rsp_ch.mean_cost !== got_fit.cost) begin
               $error("mean_cost: expected %0d, got %0d", got_fit.cost, rsp_ch.mean_cost);
               mismatches++;
            end
            if (rsp_ch.intercept_out !== got_fit.icpt) begin
               $error("intercept_out: expected %0d, got %0d",
                      $signed(got_fit.icpt), $signed(rsp_ch.intercept_out));
               mismatches++;
            end
            if (rsp_ch.slope_out !== got_fit.slope) begin
               $error("slope_out: expected %0d, got %0d",
                      $signed(got_fit.slope), $signed(rsp_ch.slope_out));
               mismatches++;
            end
            if (rsp_ch.used_samples !== got_fit.used) begin
               $error("used_samples: expected %0d, got %0d", got_fit.used,
                      rsp_ch.used_samples);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (reset === 1'b0);
      @(posedge clock);

      // empty store, ignored code, tiny fits at the reset step size
      push_request(ACT_EVAL, 32'h7FFF_FFFF, 32'h8000_0000);
      push_request(ACT_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF);
      push_request(ACT_NONE, 32'hFFFF_FFFF, 32'h0000_0000);
      push_request(ACT_LOAD, 32'h0002_0000, 32'h0005_0000);
      push_request(ACT_EVAL, 32'h0, 32'h0);
      push_request(ACT_UPDATE, 32'h0, 32'h0);
      push_request(ACT_LOAD, -32'sd98304, -32'sd32768);
      push_request(ACT_LOAD, 32'h0, 32'h0);
      push_request(ACT_NONE, 32'h0, 32'hFFFF_FFFF);
      push_request(ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_request(ACT_UPDATE, 32'h0, 32'h0);
      push_request(ACT_LOAD, 32'h0000_0001, 32'hFFFF_FFFF);
      push_request(ACT_EVAL, 32'h0, 32'h0);
      push_request(ACT_UPDATE, 32'h0, 32'h0);

      run_phase(32'h0, 0, 0, 60);

      // long hold-off on results while requests keep coming
      settle();
      write_rate(LR_RESET);
      hold_go = 1'b1;
      queue_epochs(40);

      run_phase(32'h0100_0000, 87, 0, 150);
      run_phase(32'h0040_0000, 0, 87, 150);
      run_phase(32'h4000_0000, 36, 36, 150);

      // extreme samples at the largest step size, then more fits
      settle();
      write_rate(32'hFFFF_FFFF);
      send_idle_pct  = 36;
      recv_stall_pct = 36;
      push_request(ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
      push_request(ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
      push_request(ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_request(ACT_LOAD, 32'h8000_0000, 32'h8000_0000);
      push_request(ACT_EVAL, 32'h0, 32'h0);
      push_request(ACT_UPDATE, 32'h0, 32'h0);
      push_request(ACT_UPDATE, 32'h0, 32'h0);
      push_request(ACT_LOAD, 32'h1234_5678, 32'h8765_4321);
      push_request(ACT_LOAD, 32'h0001_0000, 32'h0001_0000);
      push_request(ACT_NONE, 32'h0, 32'h0);
      push_request(ACT_EVAL, 32'h0, 32'h0);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
